// ===== src/rfft_pkg.sv =====
package rfft_pkg;

	localparam int STORE_DEPTH      = 64;
	localparam int ADDR_W           = 6;
	localparam int CNT_W            = 7;
	localparam int SMP_W            = 16;
	localparam int VAL_W            = 22;
	localparam int DEF_MAX_POINTS   = 64;
	localparam int DEF_TWIDDLE_BITS = 16;

	// sin(2*pi*k/64) in Q30, k = 0..16
	localparam logic [30:0] QSIN [0:16] = '{
		31'd0,         31'd105245103, 31'd209476638, 31'd311690799,
		31'd410903207, 31'd506158392, 31'd596538995, 31'd681174602,
		31'd759250125, 31'd830013654, 31'd892783698, 31'd946955747,
		31'd992008094, 31'd1027506862, 31'd1053110176, 31'd1068571464,
		31'd1073741824
	};

	typedef struct packed {
		logic signed [SMP_W-1:0] re;
		logic signed [SMP_W-1:0] im;
		logic [ADDR_W-1:0]       addr;
		logic                    close;
		logic [CNT_W-1:0]        count;
	} item_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PAD,
		ST_RD,
		ST_CALC,
		ST_MUL,
		ST_WRP,
		ST_WRQ,
		ST_OUT
	} state_t;

	// largest power of two not above maxp, capped at the store depth
	function automatic int cap_of(input int maxp);
		int c;
		c = 1;
		for (int k = 0; k < ADDR_W; k++) begin
			if (c * 2 <= maxp) begin
				c = c * 2;
			end
		end
		return c;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sd2097151;
		lo = -64'sd2097152;
		if (v > hi) begin
			return VAL_W'(hi);
		end else if (v < lo) begin
			return VAL_W'(lo);
		end
		return VAL_W'(v);
	endfunction

	// quarter-wave sine ROM, angle in units of 2*pi/64, Q1.(tb-1)
	function automatic logic signed [24:0] rom_sin(input logic [5:0] a, input int tb);
		logic        neg;
		logic [4:0]  b;
		logic [4:0]  i;
		logic [31:0] m;
		logic [31:0] top;
		int          s;
		s   = 31 - tb;
		neg = a[5];
		b   = a[4:0];
		i   = (b <= 5'd16) ? b : 5'(6'd32 - {1'b0, b});
		m   = ({1'b0, QSIN[i]} + (32'd1 << (s - 1))) >> s;
		top = (32'd1 << (tb - 1)) - 32'd1;
		if (m > top) begin
			m = top;
		end
		return neg ? -$signed(25'(m)) : $signed(25'(m));
	endfunction

endpackage

// ===== src/rfft_front.sv =====
module rfft_front #(
	parameter int CAP = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [15:0]            sample_real,
	input  logic signed [15:0]            sample_imag,
	input  logic                          last_sample,
	input  logic                          q_full,
	output logic                          push,
	output rfft_pkg::item_t               push_item
);
	import rfft_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cnt_nx;
	logic             close;

	assign busy   = q_full;
	assign push   = start & ~q_full;
	assign cnt_nx = count_q + CNT_W'(1);
	// frame closes on the marked sample or when the count reaches CAP
	assign close  = last_sample | (cnt_nx >= CNT_W'(CAP));

	always_comb begin
		push_item.re    = sample_real;
		push_item.im    = sample_imag;
		push_item.addr  = count_q[ADDR_W-1:0];
		push_item.close = close;
		push_item.count = cnt_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= close ? '0 : cnt_nx;
		end
	end

endmodule

// ===== src/rfft_queue.sv =====
module rfft_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rfft_pkg::item_t push_item,
	input  logic            pop,
	output logic            empty,
	output logic            full,
	output rfft_pkg::item_t head
);
	import rfft_pkg::*;

	item_t      ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== src/rfft_back.sv =====
module rfft_back #(
	parameter int TWIDDLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   inverse,
	input  logic                   empty,
	input  rfft_pkg::item_t        head,
	output logic                   pop,
	output logic                   bin_valid,
	output logic signed [21:0]     bin_real,
	output logic signed [21:0]     bin_imag,
	output logic [5:0]             bin_index,
	output logic                   last_bin
);
	import rfft_pkg::*;

	localparam int TB = TWIDDLE_BITS;
	localparam int DW = VAL_W + 1;
	localparam int PW = DW + TB;
	localparam int XW = PW + 1;
	localparam logic signed [XW-1:0] HALF = XW'(1) <<< (TB - 2);

	state_t state_q, state_d;

	logic [2*VAL_W-1:0] mem [0:STORE_DEPTH-1];
	logic [2*VAL_W-1:0] rda_s1, rdb_s1;
	logic [ADDR_W-1:0]  ra, rb, wa;
	logic [2*VAL_W-1:0] wd;
	logic               we;

	logic [ADDR_W-1:0] n_m1_q;
	logic [2:0]        lg_q;
	logic [2:0]        stg_q;
	logic [4:0]        bf_q;
	logic [ADDR_W-1:0] pad_q;
	logic [ADDR_W-1:0] k_q;

	logic [2:0]        lg_new;
	logic [CNT_W-1:0]  n_new;

	logic [2:0]        hb;
	logic [ADDR_W-1:0] t6, lo_mask, p_addr, q_addr, j6, tw_ang;
	logic [3:0]        ang_sh;
	logic              bf_last, stg_last;

	logic signed [TB-1:0] wr_q, wi_q;
	logic signed [24:0]   ws_full, wc_full;

	logic signed [2*VAL_W-1:0] sum_q;
	logic signed [DW-1:0]      dr_q, di_q;
	logic signed [PW-1:0]      prr_q, pii_q, pri_q, pir_q;
	logic signed [XW-1:0]      xr, xi;
	logic signed [VAL_W-1:0]   yr, yi;

	logic [ADDR_W-1:0] brev;
	logic signed [VAL_W-1:0] ar, ai, br_v, bi_v, vr, vi, sr, si;
	logic signed [DW-1:0]    sre, sim;

	logic                rv_s1, last_s1;
	logic [ADDR_W-1:0]   idx_s1;

	// frame length rounded up to a power of two
	always_comb begin
		lg_new = 3'd0;
		for (int k = 0; k < ADDR_W; k++) begin
			if ((CNT_W'(1) << lg_new) < head.count) begin
				lg_new = lg_new + 3'd1;
			end
		end
		n_new = CNT_W'(1) << lg_new;
	end

	// butterfly addressing: insert a zero bit at the half-span position of the index
	always_comb begin
		hb       = lg_q - 3'd1 - stg_q;
		t6       = {1'b0, bf_q};
		lo_mask  = ADDR_W'((CNT_W'(1) << hb) - CNT_W'(1));
		p_addr   = ADDR_W'(((t6 >> hb) << (hb + 3'd1)) | (t6 & lo_mask));
		q_addr   = p_addr | ADDR_W'(CNT_W'(1) << hb);
		j6       = t6 & lo_mask;
		ang_sh   = 4'(stg_q) + 4'd6 - 4'(lg_q);
		tw_ang   = ADDR_W'(12'(j6) << ang_sh);
		bf_last  = (bf_q == n_m1_q[ADDR_W-1:1]);
		stg_last = (stg_q == lg_q - 3'd1);
		wc_full  = rom_sin(tw_ang + 6'd16, TB);
		ws_full  = rom_sin(tw_ang, TB);
	end

	assign brev = ADDR_W'({k_q[0], k_q[1], k_q[2], k_q[3], k_q[4], k_q[5]} >> (3'd6 - lg_q));

	assign ar   = rda_s1[2*VAL_W-1:VAL_W];
	assign ai   = rda_s1[VAL_W-1:0];
	assign br_v = rdb_s1[2*VAL_W-1:VAL_W];
	assign bi_v = rdb_s1[VAL_W-1:0];
	assign sre  = DW'(ar) + DW'(br_v);
	assign sim  = DW'(ai) + DW'(bi_v);

	assign xr = XW'(prr_q) - XW'(pii_q) + HALF;
	assign xi = XW'(pri_q) + XW'(pir_q) + HALF;
	assign yr = sat_val(64'(xr >>> (TB - 1)));
	assign yi = sat_val(64'(xi >>> (TB - 1)));

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		we      = 1'b0;
		wa      = p_addr;
		wd      = sum_q;
		ra      = p_addr;
		rb      = q_addr;
		case (state_q)
			ST_LOAD: begin
				if (!empty) begin
					pop = 1'b1;
					we  = 1'b1;
					wa  = head.addr;
					wd  = {VAL_W'(head.re), VAL_W'(head.im)};
					if (head.close) begin
						if (head.count < n_new) begin
							state_d = ST_PAD;
						end else if (lg_new == 3'd0) begin
							state_d = ST_OUT;
						end else begin
							state_d = ST_RD;
						end
					end
				end
			end
			ST_PAD: begin
				we = 1'b1;
				wa = pad_q;
				wd = '0;
				if (pad_q == n_m1_q) begin
					state_d = ST_RD;
				end
			end
			ST_RD:   state_d = ST_CALC;
			ST_CALC: state_d = ST_MUL;
			ST_MUL:  state_d = ST_WRP;
			ST_WRP: begin
				we      = 1'b1;
				state_d = ST_WRQ;
			end
			ST_WRQ: begin
				we = 1'b1;
				wa = q_addr;
				wd = {yr, yi};
				if (bf_last && stg_last) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_RD;
				end
			end
			ST_OUT: begin
				ra = brev;
				if (k_q == n_m1_q) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
	end

	always_ff @(posedge clk) begin
		rda_s1 <= mem[ra];
		rdb_s1 <= mem[rb];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_m1_q <= '0;
			lg_q   <= '0;
			stg_q  <= '0;
			bf_q   <= '0;
			pad_q  <= '0;
			k_q    <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (!empty && head.close) begin
						n_m1_q <= ADDR_W'(n_new - CNT_W'(1));
						lg_q   <= lg_new;
						stg_q  <= '0;
						bf_q   <= '0;
						k_q    <= '0;
						pad_q  <= head.count[ADDR_W-1:0];
					end
				end
				ST_PAD: pad_q <= pad_q + ADDR_W'(1);
				ST_WRQ: begin
					if (bf_last) begin
						bf_q  <= '0;
						stg_q <= stg_q + 3'd1;
					end else begin
						bf_q <= bf_q + 5'd1;
					end
				end
				ST_OUT: k_q <= k_q + ADDR_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			wr_q <= TB'(wc_full);
			wi_q <= inverse ? TB'(ws_full) : TB'(-ws_full);
		end
		if (state_q == ST_CALC) begin
			sum_q <= {sat_val(64'(sre)), sat_val(64'(sim))};
			dr_q  <= DW'(ar) - DW'(br_v);
			di_q  <= DW'(ai) - DW'(bi_v);
		end
		if (state_q == ST_MUL) begin
			prr_q <= PW'(dr_q) * PW'(wr_q);
			pii_q <= PW'(di_q) * PW'(wi_q);
			pri_q <= PW'(dr_q) * PW'(wi_q);
			pir_q <= PW'(di_q) * PW'(wr_q);
		end
	end

	// output stage: optional 1/N scaling with round half up
	always_comb begin
		vr = ar;
		vi = ai;
		sr = (lg_q == 3'd0) ? vr :
			sat_val(64'((DW'(vr) + (DW'(1) <<< (lg_q - 3'd1))) >>> lg_q));
		si = (lg_q == 3'd0) ? vi :
			sat_val(64'((DW'(vi) + (DW'(1) <<< (lg_q - 3'd1))) >>> lg_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1     <= 1'b0;
			bin_valid <= 1'b0;
		end else begin
			rv_s1     <= (state_q == ST_OUT);
			bin_valid <= rv_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= k_q;
		last_s1 <= (k_q == n_m1_q);
		if (rv_s1) begin
			bin_real  <= inverse ? sr : vr;
			bin_imag  <= inverse ? si : vi;
			bin_index <= idx_s1;
			last_bin  <= last_s1;
		end
	end

endmodule

// ===== src/radix2_fft_engine_top.sv =====
// Radix-2 DIF FFT. Samples are taken one per cycle at start while busy is low;
// a two-entry queue lets loading run ahead of the engine, and busy rises when it
// is full. On the sample marked last (or when CAP samples are in) the frame is
// zero-padded to N = next power of two, then one shared butterfly unit runs
// (N/2)*log2(N) butterflies (read, add, multiply, write top, write bottom,
// none overlapped). Bins leave in natural order, one per cycle, via the read and
// output registers; bin_valid marks each for one cycle and cannot be stalled.
// inverse_mode must be written only while idle; the block does not enforce it.
module radix2_fft_engine_top #(
	parameter int MAX_POINTS   = rfft_pkg::DEF_MAX_POINTS,
	parameter int TWIDDLE_BITS = rfft_pkg::DEF_TWIDDLE_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               inverse_mode_we,
	input  logic               inverse_mode_wdata,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] sample_real,
	input  logic signed [15:0] sample_imag,
	input  logic               last_sample,
	output logic               bin_valid,
	output logic signed [21:0] bin_real,
	output logic signed [21:0] bin_imag,
	output logic [5:0]         bin_index,
	output logic               last_bin
);
	import rfft_pkg::*;

	localparam int CAP = cap_of(MAX_POINTS);

	logic  inverse_q;
	logic  q_full, q_empty, push, pop;
	item_t push_item, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inverse_q <= 1'b0;
		end else if (inverse_mode_we) begin
			inverse_q <= inverse_mode_wdata;
		end
	end

	rfft_front #(.CAP(CAP)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.sample_real (sample_real),
		.sample_imag (sample_imag),
		.last_sample (last_sample),
		.q_full      (q_full),
		.push        (push),
		.push_item   (push_item)
	);

	rfft_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.empty     (q_empty),
		.full      (q_full),
		.head      (head)
	);

	rfft_back #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.inverse   (inverse_q),
		.empty     (q_empty),
		.head      (head),
		.pop       (pop),
		.bin_valid (bin_valid),
		.bin_real  (bin_real),
		.bin_imag  (bin_imag),
		.bin_index (bin_index),
		.last_bin  (last_bin)
	);

endmodule

// ===== src/rfft_chk.sv =====
module rfft_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       bin_valid,
	input logic [5:0] bin_index,
	input logic       last_bin
);

	a_bin_known: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid |-> !$isunknown({bin_index, last_bin}))
		else $error("unknown bin index or last flag on a transfer");

	a_first_bin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(bin_valid) |-> (bin_index == 6'd0))
		else $error("frame readout does not start at bin 0");

	a_bins_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_valid && !last_bin) |=> (bin_valid && bin_index == $past(bin_index) + 6'd1))
		else $error("bin sequence broken");

	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(bin_valid && last_bin) |=> !bin_valid)
		else $error("transfer right after last bin");

endmodule

bind radix2_fft_engine_top rfft_chk u_rfft_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.bin_valid (bin_valid),
	.bin_index (bin_index),
	.last_bin  (last_bin)
);

// ===== tb/sv/tb_radix2_fft_engine_top.sv =====
class fft_bin_board;
	int unsigned mismatches;
	int unsigned bins_seen;
	int unsigned frames;
	logic inv;
	logic signed [21:0] frame_re[64];
	logic signed [21:0] frame_im[64];
	int unsigned fill;
	logic signed [21:0] want_re[$];
	logic signed [21:0] want_im[$];
	logic [5:0] want_idx[$];
	logic want_last[$];

	function new();
		mismatches = 0;
		bins_seen = 0;
		frames = 0;
		inv = 1'b0;
		fill = 0;
	endfunction

	function longint clamp22(longint v);
		if (v > 64'sd2097151) return 64'sd2097151;
		if (v < -64'sd2097152) return -64'sd2097152;
		return v;
	endfunction

	function longint rnd_shift(longint v, int s);
		if (s == 0) return v;
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	// sine at angle a in units of 2*pi/64, Q1.15 rounded from Q30
	function longint twiddle_sin(int a);
		int b;
		int i;
		longint m;
		a = a & 63;
		b = a & 31;
		i = (b <= 16) ? b : 32 - b;
		m = (longint'(rfft_pkg::QSIN[i]) + (64'sd1 <<< 14)) >>> 15;
		if (m > 32767) m = 32767;
		return (a >= 32) ? -m : m;
	endfunction

	function void run_fft(int n, int lg);
		int groups;
		int size;
		int h;
		int p;
		int q;
		int a;
		longint wr;
		longint wi;
		longint ar;
		longint ai;
		longint br;
		longint bi;
		longint dr;
		longint di;
		groups = 1;
		size = n;
		while (size > 1) begin
			h = size / 2;
			for (int g = 0; g < groups; g++) begin
				for (int j = 0; j < h; j++) begin
					p = g * size + j;
					q = p + h;
					a = ((j * groups) << (6 - lg)) & 63;
					wr = twiddle_sin(a + 16);
					wi = inv ? twiddle_sin(a) : -twiddle_sin(a);
					ar = longint'(frame_re[p]); ai = longint'(frame_im[p]);
					br = longint'(frame_re[q]); bi = longint'(frame_im[q]);
					dr = ar - br; di = ai - bi;
					frame_re[p] = 22'(clamp22(ar + br));
					frame_im[p] = 22'(clamp22(ai + bi));
					frame_re[q] = 22'(clamp22(rnd_shift(dr * wr - di * wi, 15)));
					frame_im[q] = 22'(clamp22(rnd_shift(dr * wi + di * wr, 15)));
				end
			end
			groups *= 2;
			size = h;
		end
	endfunction

	// note one accepted sample; a closing sample queues every bin of the frame
	function void note_sample(logic signed [15:0] re, logic signed [15:0] im, logic last);
		int n;
		int lg;
		int r;
		longint vr;
		longint vi;
		frame_re[fill] = 22'(re);
		frame_im[fill] = 22'(im);
		fill++;
		if (!last && fill < 64) return;
		n = 1;
		lg = 0;
		while (n < fill) begin
			n *= 2;
			lg++;
		end
		for (int i = fill; i < n; i++) begin
			frame_re[i] = '0;
			frame_im[i] = '0;
		end
		run_fft(n, lg);
		for (int k = 0; k < n; k++) begin
			r = 0;
			for (int b = 0; b < lg; b++)
				if ((k >> b) & 1) r |= 1 << (lg - 1 - b);
			vr = longint'(frame_re[r]);
			vi = longint'(frame_im[r]);
			if (inv) begin
				vr = clamp22(rnd_shift(vr, lg));
				vi = clamp22(rnd_shift(vi, lg));
			end
			want_re.insert(want_re.size(), 22'(vr));
			want_im.insert(want_im.size(), 22'(vi));
			want_idx.insert(want_idx.size(), 6'(k));
			want_last.insert(want_last.size(), k == n - 1);
		end
		fill = 0;
		frames++;
	endfunction

	function int pending();
		return want_re.size();
	endfunction

	task report(string what, longint got, longint exp_v);
		$display("mismatch on %s: got %0d, expected %0d", what, got, exp_v);
		mismatches++;
	endtask

	task check_bin(logic signed [21:0] re, logic signed [21:0] im, logic [5:0] idx, logic lst);
		bins_seen++;
		if (want_re.size() == 0) begin
			report("unexpected bin index", longint'(idx), -1);
			return;
		end
		if (re !== want_re[0]) report("bin_real", longint'(re), longint'(want_re[0]));
		if (im !== want_im[0]) report("bin_imag", longint'(im), longint'(want_im[0]));
		if (idx !== want_idx[0]) report("bin_index", longint'(idx), longint'(want_idx[0]));
		if (lst !== want_last[0]) report("last_bin", longint'(lst), longint'(want_last[0]));
		void'(want_re.pop_front());
		void'(want_im.pop_front());
		void'(want_idx.pop_front());
		void'(want_last.pop_front());
	endtask
endclass

module tb_radix2_fft_engine_top;
	import rfft_pkg::*;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic inverse_mode_we = 1'b0;
	logic inverse_mode_wdata = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [15:0] sample_real = '0;
	logic signed [15:0] sample_imag = '0;
	logic last_sample = 1'b0;
	logic bin_valid;
	logic signed [21:0] bin_real;
	logic signed [21:0] bin_imag;
	logic [5:0] bin_index;
	logic last_bin;

	fft_bin_board board = new();
	int unsigned idle_cycles = 0;
	int unsigned samples_sent = 0;
	bit timed_out = 1'b0;

	always #4 clk = ~clk;

	radix2_fft_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.inverse_mode_we(inverse_mode_we), .inverse_mode_wdata(inverse_mode_wdata),
		.start(start), .busy(busy),
		.sample_real(sample_real), .sample_imag(sample_imag), .last_sample(last_sample),
		.bin_valid(bin_valid), .bin_real(bin_real), .bin_imag(bin_imag),
		.bin_index(bin_index), .last_bin(last_bin)
	);

	always @(posedge clk) begin
		if (arst_n) begin
			if (bin_valid) begin
				board.check_bin(bin_real, bin_imag, bin_index, last_bin);
			end
			if ((start && !busy) || bin_valid) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG && !timed_out) begin
				timed_out = 1'b1;
				$display("watchdog expired with %0d bins pending", board.pending());
				$display("tb_radix2_fft_engine_top: FAIL");
				$finish;
			end
		end
	end

	// one sample transfer; start stays high only while transfers go back to back
	task send_sample(logic signed [15:0] re, logic signed [15:0] im, logic last, bit hold);
		sample_real <= re;
		sample_imag <= im;
		last_sample <= last;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		board.note_sample(re, im, last);
		samples_sent++;
		@(negedge clk);
		if (!hold) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task gap(int n);
		repeat (n) @(negedge clk);
	endtask

	task drain();
		while (board.pending() != 0) @(negedge clk);
		gap(8);
	endtask

	task set_mode(logic m);
		drain();
		inverse_mode_wdata <= m;
		inverse_mode_we <= 1'b1;
		@(negedge clk);
		inverse_mode_we <= 1'b0;
		board.inv = m;
	endtask

	function logic signed [15:0] pick_val();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 15)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task send_frame(int len, bit random_gaps);
		bit hold;
		for (int i = 0; i < len; i++) begin
			hold = !random_gaps || ($urandom_range(0, 3) != 0);
			if (i == len - 1) hold = 1'b0;
			send_sample(pick_val(), pick_val(), i == len - 1, hold);
			if (!hold) gap($urandom_range(0, 6));
		end
	endtask

	initial begin
		int len;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single sample, extremes, impulse, dc, padding
		send_sample(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
		send_sample(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
		send_sample(16'sh0001, 16'sh0000, 1'b0, 1'b1);
		send_sample(16'sh0000, 16'sh0000, 1'b0, 1'b1);
		send_sample(16'sh0000, 16'sh0000, 1'b1, 1'b0);
		for (int i = 0; i < 4; i++)
			send_sample(16'sh7fff, 16'sh7fff, i == 3, i != 3);
		for (int i = 0; i < 5; i++)
			send_sample(16'sh8000, 16'sh8000, i == 4, i != 4);
		set_mode(1'b1);
		send_sample(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
		for (int i = 0; i < 3; i++)
			send_sample(16'sh7fff, 16'sh8000, i == 2, i != 2);
		set_mode(1'b0);

		// full store closes without a last marker
		for (int i = 0; i < 64; i++)
			send_sample(pick_val(), pick_val(), 1'b0, i != 63);
		drain();

		// random frames, mostly short, mode flipped between phases
		for (int ph = 0; ph < 4; ph++) begin
			set_mode(ph[0]);
			while (samples_sent < 105 + 15 * ph) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
					: $urandom_range(1, 9);
				send_frame(len, $urandom_range(0, 3) != 0);
			end
			drain();
		end

		$display("sent %0d samples in %0d frames, checked %0d bins, both modes",
			samples_sent, board.frames, board.bins_seen);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("tb_radix2_fft_engine_top: PASS");
		end else begin
			$display("tb_radix2_fft_engine_top: FAIL");
		end
		$finish;
	end
endmodule
